### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion wrappers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on the rising clock edge, off while reset is asserted
`define RSI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define RSI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/rsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg
// Types and constants shared by the RSI threshold signal block.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int PRICE_IN_W = 32;
  localparam int WINDOW_W   = 7;
  localparam int LEVEL_W    = 15;
  localparam int RSI_W      = 15;
  localparam int SIG_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERSOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVERBOUGHT = 2'd2;

  localparam logic [SIG_W-1:0] SIG_NONE = 2'd0;
  localparam logic [SIG_W-1:0] SIG_BUY  = 2'd1;
  localparam logic [SIG_W-1:0] SIG_SELL = 2'd2;

  localparam logic [WINDOW_W-1:0] WINDOW_RST     = 7'd14;
  localparam logic [LEVEL_W-1:0]  OVERSOLD_RST   = 15'd7680;
  localparam logic [LEVEL_W-1:0]  OVERBOUGHT_RST = 15'd17920;

  // rsi with no losses in the window (rs of 100)
  localparam logic [RSI_W-1:0] RSI_NO_LOSS = 15'd25346;

  // scale of 25600 = 2^14 + 2^13 + 2^10
  localparam int SCALE_SH_HI  = 14;
  localparam int SCALE_SH_MID = 13;
  localparam int SCALE_SH_LO  = 10;

  typedef struct packed {
    logic             done;
    logic [RSI_W-1:0] quot;
  } div_result_t;

endpackage

### hdl/rsi_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_ring
// Change history memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rsi_ring #(
  parameter  int DEPTH  = 64,
  parameter  int DATA_W = 33,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/rsi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_div
// Serial restoring divider for 25600 * gain / total, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rsi_div
  import rsi_pkg::*;
#(
  parameter int SUM_W = 38
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] gain_i,
  input  logic [SUM_W-1:0] total_i,
  output div_result_t      result_o
);

  localparam int NUM_W = SUM_W + RSI_W;
  localparam int CNT_W = $clog2(RSI_W + 1);

  logic [NUM_W-1:0] num;
  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   diff;
  logic             take;
  logic [SUM_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0] den_q;
  logic [RSI_W-1:0] bits_q, bits_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  always_comb begin
    num = (NUM_W'(gain_i) << SCALE_SH_HI) + (NUM_W'(gain_i) << SCALE_SH_MID)
        + (NUM_W'(gain_i) << SCALE_SH_LO);
    trial = {rem_q, bits_q[RSI_W-1]};
    diff  = trial - {1'b0, den_q};
    take  = (trial >= {1'b0, den_q});
    rem_d  = rem_q;
    bits_d = bits_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num[NUM_W-1:RSI_W];
      bits_d = num[RSI_W-1:0];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = take ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      bits_d = {bits_q[RSI_W-2:0], take};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(RSI_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    bits_q <= bits_d;
    if (start_i) begin
      den_q <= total_i;
    end
  end

  assign result_o.done = done_q;
  assign result_o.quot = bits_q;

endmodule

### hdl/rsi_threshold_signal_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_threshold_signal_top
// Simple-average RSI over a ring of price changes with a buy/sell threshold.
// ----------------------------------------------------------------------------
// sequence: an accepted price passes the update, add and eval states, then the
//   15-step serial divider when the window is full and the loss sum is nonzero,
//   then the done state; no new price is taken until its result is registered
// reset: control state and sums cleared, levels and window at their defaults;
//   ring contents are undefined and are only used after being written,
//   so no clearing pass
module rsi_threshold_signal_top
  import rsi_pkg::*;
#(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PRICE_IN_W-1:0] s_axis_tdata,  // close_price
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // trade_signal, rsi_value, rsi_valid
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PTR_W   = $clog2(MAX_WINDOW);
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W   = $clog2(MAX_WINDOW + 2);
  localparam int ENTRY_W = PRICE_BITS + 1;
  localparam int SUM_W   = PRICE_BITS + $clog2(MAX_WINDOW);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UPDATE = 3'd1;
  localparam logic [2:0] ST_ADD    = 3'd2;
  localparam logic [2:0] ST_EVAL   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [WINDOW_W-1:0]   window_q, window_d;
  logic [LEVEL_W-1:0]    oversold_q, oversold_d;
  logic [LEVEL_W-1:0]    overbought_q, overbought_d;
  logic [PRICE_BITS-1:0] prev_q, prev_d;
  logic [CNT_W-1:0]      samples_q, samples_d;
  logic [PTR_W-1:0]      ptr_q, ptr_d;
  logic [SUM_W-1:0]      gain_q, gain_d;
  logic [SUM_W-1:0]      loss_q, loss_d;
  logic                  m_valid_q, m_valid_d;

  logic [PRICE_BITS-1:0] price_q, price_d;
  logic [PRICE_BITS-1:0] mag_q, mag_d;
  logic                  is_loss_q, is_loss_d;
  logic [RSI_W-1:0]      rsi_q, rsi_d;
  logic                  valid_q, valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  logic [PRICE_IN_W+PRICE_BITS-1:0] price_ext;
  logic [PRICE_BITS-1:0] price_in;
  logic [WIN_W-1:0]      win;
  logic [CNT_W-1:0]      win_plus1;
  logic                  full;
  logic [PRICE_BITS-1:0] rise;
  logic [PRICE_BITS-1:0] fall;
  logic                  accept;
  logic                  ring_we;
  logic                  ring_re;
  logic [ENTRY_W-1:0]    ring_wdata;
  logic [ENTRY_W-1:0]    ring_rdata;
  logic [PRICE_BITS-1:0] old_mag;
  logic                  old_loss;
  logic                  div_start;
  logic [SUM_W-1:0]      div_total;
  div_result_t           div_res;
  logic [SIG_W-1:0]      sig;

  rsi_ring #(
    .DEPTH  (MAX_WINDOW),
    .DATA_W (ENTRY_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ptr_q),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (ptr_q),
    .rdata_o (ring_rdata)
  );

  rsi_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .gain_i   (gain_q),
    .total_i  (div_total),
    .result_o (div_res)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign price_ext     = {{PRICE_BITS{1'b0}}, s_axis_tdata};
  assign price_in      = price_ext[PRICE_BITS-1:0];
  assign ring_re       = accept;
  assign ring_wdata    = {is_loss_d, mag_d};
  assign old_mag       = ring_rdata[PRICE_BITS-1:0];
  assign old_loss      = ring_rdata[PRICE_BITS];
  assign rise          = price_q - prev_q;
  assign fall          = prev_q - price_q;
  assign div_total     = gain_q + loss_q;

  // effective window: zero acts as one, large values clamp
  always_comb begin
    priority if (window_q == '0) begin
      win = WIN_W'(1);
    end else if (32'(window_q) > MAX_WINDOW) begin
      win = WIN_W'(MAX_WINDOW);
    end else begin
      win = WIN_W'(window_q);
    end
  end

  assign win_plus1 = CNT_W'(win) + 1'b1;
  assign full      = (samples_q >= win_plus1);

  always_comb begin
    sig = SIG_NONE;
    if (valid_q) begin
      priority if (rsi_q <= oversold_q) begin
        sig = SIG_BUY;
      end else if (rsi_q >= overbought_q) begin
        sig = SIG_SELL;
      end else begin
        sig = SIG_NONE;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    window_d     = window_q;
    oversold_d   = oversold_q;
    overbought_d = overbought_q;
    prev_d       = prev_q;
    samples_d    = samples_q;
    ptr_d        = ptr_q;
    gain_d       = gain_q;
    loss_d       = loss_q;
    m_valid_d    = m_valid_q;
    price_d      = price_q;
    mag_d        = mag_q;
    is_loss_d    = is_loss_q;
    rsi_d        = rsi_q;
    valid_d      = valid_q;
    m_data_d     = m_data_q;
    ring_we      = 1'b0;
    div_start    = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          price_d = price_in;
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        mag_d     = '0;
        is_loss_d = 1'b0;
        if (samples_q != '0) begin
          is_loss_d = !(price_q > prev_q);
          mag_d     = is_loss_d ? fall : rise;
          if (full) begin
            if (old_loss) begin
              loss_d = loss_q - SUM_W'(old_mag);
            end else begin
              gain_d = gain_q - SUM_W'(old_mag);
            end
          end
          ring_we = 1'b1;
          ptr_d   = (32'(ptr_q) + 1 >= 32'(win)) ? '0 : ptr_q + 1'b1;
        end
        prev_d = price_q;
        if (samples_q < win_plus1) begin
          samples_d = samples_q + 1'b1;
        end
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (is_loss_q) begin
          loss_d = loss_q + SUM_W'(mag_q);
        end else begin
          gain_d = gain_q + SUM_W'(mag_q);
        end
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        priority if (!full) begin
          valid_d = 1'b0;
          rsi_d   = '0;
          state_d = ST_DONE;
        end else if (loss_q == '0) begin
          valid_d = 1'b1;
          rsi_d   = RSI_NO_LOSS;
          state_d = ST_DONE;
        end else begin
          valid_d   = 1'b1;
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          rsi_d   = div_res.quot;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_d  = OUT_DATA_W'({valid_q, rsi_q, sig});
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW: begin
          window_d  = cfg_data_i[WINDOW_W-1:0];
          samples_d = '0;
          ptr_d     = '0;
          gain_d    = '0;
          loss_d    = '0;
          prev_d    = '0;
        end
        REG_OVERSOLD: begin
          oversold_d = cfg_data_i[LEVEL_W-1:0];
        end
        REG_OVERBOUGHT: begin
          overbought_d = cfg_data_i[LEVEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      window_q     <= WINDOW_RST;
      oversold_q   <= OVERSOLD_RST;
      overbought_q <= OVERBOUGHT_RST;
      prev_q       <= '0;
      samples_q    <= '0;
      ptr_q        <= '0;
      gain_q       <= '0;
      loss_q       <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      window_q     <= window_d;
      oversold_q   <= oversold_d;
      overbought_q <= overbought_d;
      prev_q       <= prev_d;
      samples_q    <= samples_d;
      ptr_q        <= ptr_d;
      gain_q       <= gain_d;
      loss_q       <= loss_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q   <= price_d;
    mag_q     <= mag_d;
    is_loss_q <= is_loss_d;
    rsi_q     <= rsi_d;
    valid_q   <= valid_d;
    m_data_q  <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### hdl/rsi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks for the RSI threshold signal block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsi_checker
  import rsi_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [PRICE_IN_W-1:0] s_axis_tdata,  // close_price
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,  // trade_signal, rsi_value, rsi_valid
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  // stalled result holds
  `RSI_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")

  // one price in flight at a time
  `RSI_ASSERT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second price taken while busy")

  // no signal and zero rsi before the window fills
  `RSI_ASSERT(a_invalid_quiet, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[17] |-> m_axis_tdata[16:0] == 17'd0, "signal or rsi set on invalid result")

  // rsi within scale and signal code defined
  `RSI_ASSERT(a_rsi_range, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[16:2] <= 15'd25600 && m_axis_tdata[1:0] != 2'd3, "rsi or signal out of range")

  // no result while in reset
  `RSI_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind rsi_threshold_signal_top rsi_checker u_rsi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_we_i      (cfg_we_i),
  .cfg_idx_i     (cfg_idx_i),
  .cfg_data_i    (cfg_data_i)
);

### tb/rsi_threshold_signal_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_threshold_signal_top_tb
// Drives closing prices into the RSI threshold block and checks every
// result against a directed plan's values or an in-bench model of the
// windowed gain/loss sums, the Q8 RSI ratio and the buy/sell decision.
// A short directed plan covers reset values, price extremes, the no-loss
// case, tied levels and window saturation. Random phases then rewrite the
// registers and stream price walks with random stalls on both sides.
// ----------------------------------------------------------------------------
module rsi_threshold_signal_top_tb;
  import rsi_pkg::*;

  localparam int ITEMS_TOTAL  = 1250;
  localparam int CALM_ITEMS   = 100;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 30;
  localparam int RING_DEPTH   = 64;
  localparam logic [63:0] RSI_FULL_SCALE = 64'd25600;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic {ROW_PRICE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    logic [SIG_W-1:0] sig;
    logic [RSI_W-1:0] rsi;
    logic             valid;
  } rsi_result_t;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [PRICE_IN_W-1:0] price;
    logic                  chk;
    rsi_result_t           res;
  } plan_row_t;

  localparam int PLAN_LEN = 31;
  localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'h0000_0000, 1'b1, '{SIG_NONE, 15'd0, 1'b0}},
    '{ROW_WRITE, REG_WINDOW, 15'd1, 32'd0, 1'b0, '{SIG_NONE, 15'd0, 1'b0}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'h0000_0000, 1'b1, '{SIG_NONE, 15'd0, 1'b0}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'hFFFF_FFFF, 1'b1, '{SIG_SELL, RSI_NO_LOSS, 1'b1}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'h0000_0000, 1'b1, '{SIG_BUY, 15'd0, 1'b1}},
    // flat price: both sums zero
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'h0000_0000, 1'b1, '{SIG_SELL, RSI_NO_LOSS, 1'b1}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'h5555_5555, 1'b1, '{SIG_SELL, RSI_NO_LOSS, 1'b1}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'hAAAA_AAAA, 1'b1, '{SIG_SELL, RSI_NO_LOSS, 1'b1}},
    '{ROW_WRITE, REG_WINDOW, 15'd2, 32'd0, 1'b0, '{SIG_NONE, 15'd0, 1'b0}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'd100, 1'b1, '{SIG_NONE, 15'd0, 1'b0}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'd150, 1'b1, '{SIG_NONE, 15'd0, 1'b0}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'd100, 1'b1, '{SIG_NONE, 15'd12800, 1'b1}},
    '{ROW_WRITE, REG_OVERSOLD, 15'd12800, 32'd0, 1'b0, '{SIG_NONE, 15'd0, 1'b0}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'd150, 1'b1, '{SIG_BUY, 15'd12800, 1'b1}},
    // both levels met, buy wins
    '{ROW_WRITE, REG_OVERBOUGHT, 15'd12800, 32'd0, 1'b0, '{SIG_NONE, 15'd0, 1'b0}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'd100, 1'b1, '{SIG_BUY, 15'd12800, 1'b1}},
    '{ROW_WRITE, REG_OVERSOLD, 15'd0, 32'd0, 1'b0, '{SIG_NONE, 15'd0, 1'b0}},
    '{ROW_WRITE, REG_OVERBOUGHT, 15'd25600, 32'd0, 1'b0, '{SIG_NONE, 15'd0, 1'b0}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'd100, 1'b1, '{SIG_BUY, 15'd0, 1'b1}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'd175, 1'b1, '{SIG_NONE, RSI_NO_LOSS, 1'b1}},
    '{ROW_WRITE, REG_OVERBOUGHT, 15'h7FFF, 32'd0, 1'b0, '{SIG_NONE, 15'd0, 1'b0}},
    // unused index, must be ignored
    '{ROW_WRITE, REG_UNUSED, 15'h5555, 32'd0, 1'b0, '{SIG_NONE, 15'd0, 1'b0}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'd200, 1'b1, '{SIG_NONE, RSI_NO_LOSS, 1'b1}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'd190, 1'b0, '{SIG_NONE, 15'd0, 1'b0}},
    // zero window acts as one
    '{ROW_WRITE, REG_WINDOW, 15'd0, 32'd0, 1'b0, '{SIG_NONE, 15'd0, 1'b0}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'd7, 1'b1, '{SIG_NONE, 15'd0, 1'b0}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'd3, 1'b1, '{SIG_BUY, 15'd0, 1'b1}},
    // oversized window saturates
    '{ROW_WRITE, REG_WINDOW, 15'h7FFF, 32'd0, 1'b0, '{SIG_NONE, 15'd0, 1'b0}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'd1, 1'b1, '{SIG_NONE, 15'd0, 1'b0}},
    '{ROW_PRICE, REG_WINDOW, 15'd0, 32'd2, 1'b1, '{SIG_NONE, 15'd0, 1'b0}},
    '{ROW_WRITE, REG_OVERSOLD, 15'd7680, 32'd0, 1'b0, '{SIG_NONE, 15'd0, 1'b0}}
  };

  bit                    clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [PRICE_IN_W-1:0] s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // model state
  logic [WINDOW_W-1:0]   win_reg;
  logic [LEVEL_W-1:0]    lo_level;
  logic [LEVEL_W-1:0]    hi_level;
  logic [PRICE_IN_W-1:0] last_price;
  int unsigned           seen;
  int unsigned           ring_ptr;
  logic [31:0]           chg_mag [RING_DEPTH];
  logic                  chg_loss [RING_DEPTH];
  logic [63:0]           gains;
  logic [63:0]           losses;

  rsi_result_t pending_rsi [$];
  int unsigned fail_count;
  int unsigned prices_sent;
  int unsigned phase_count;
  int unsigned n_buy, n_sell, n_none, n_invalid;
  int unsigned quiet_cycles;
  int unsigned tx_idle_pct, rx_idle_pct;
  int unsigned rx_stall;
  bit          calm;

  rsi_threshold_signal_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic rsi_result_t predict_rsi(input logic [PRICE_IN_W-1:0] price);
    int unsigned p;
    int unsigned slot;
    logic [31:0] mag;
    logic        is_loss;
    rsi_result_t r;
    p = (win_reg == 0) ? 1 : ((win_reg > RING_DEPTH) ? RING_DEPTH : win_reg);
    r = '0;
    if (seen > 0) begin
      slot = ring_ptr % p;
      if (price > last_price) begin
        mag = price - last_price;
        is_loss = 1'b0;
      end else begin
        mag = last_price - price;
        is_loss = 1'b1;
      end
      if (seen >= p + 1) begin
        if (chg_loss[slot]) losses -= chg_mag[slot];
        else gains -= chg_mag[slot];
      end
      chg_mag[slot] = mag;
      chg_loss[slot] = is_loss;
      if (is_loss) losses += mag;
      else gains += mag;
      ring_ptr = (slot + 1) % p;
    end
    last_price = price;
    if (seen < p + 1) seen++;
    if (seen >= p + 1) begin
      r.valid = 1'b1;
      if (losses == 0) r.rsi = RSI_NO_LOSS;
      else r.rsi = RSI_W'((RSI_FULL_SCALE * gains) / (gains + losses));
      if (r.rsi <= lo_level) r.sig = SIG_BUY;
      else if (r.rsi >= hi_level) r.sig = SIG_SELL;
      else r.sig = SIG_NONE;
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    s_axis_tvalid <= 1'b0;
    while (pending_rsi.size() != 0) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_WINDOW: begin
        win_reg    = data[WINDOW_W-1:0];
        seen       = 0;
        ring_ptr   = 0;
        gains      = '0;
        losses     = '0;
        last_price = '0;
      end
      REG_OVERSOLD:   lo_level = data;
      REG_OVERBOUGHT: hi_level = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic push_price(input logic [PRICE_IN_W-1:0] price, input logic typed,
                            input rsi_result_t typed_res);
    rsi_result_t res;
    if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= price;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = predict_rsi(price);
    pending_rsi.push_back(typed ? typed_res : res);
    prices_sent++;
    @(negedge clk_i);
  endtask

  // result side back-pressure
  always @(negedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
      rx_stall = 0;
    end else if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall--;
    end else if ($urandom_range(0, 99) < rx_idle_pct) begin
      m_axis_tready <= 1'b0;
      rx_stall = $urandom_range(0, 14);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    rsi_result_t got;
    rsi_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.sig   = m_axis_tdata[1:0];
      got.rsi   = m_axis_tdata[16:2];
      got.valid = m_axis_tdata[17];
      if (pending_rsi.size() == 0) begin
        $display("%0t: unexpected result transaction sig=%0d rsi=%0d valid=%0d",
                 $time, got.sig, got.rsi, got.valid);
        fail_count++;
      end else begin
        want = pending_rsi.pop_front();
        if (got.sig !== want.sig) begin
          $display("%0t: trade_signal mismatch: expected %0d, actual %0d",
                   $time, want.sig, got.sig);
          fail_count++;
        end
        if (got.rsi !== want.rsi) begin
          $display("%0t: rsi_value mismatch: expected %0d, actual %0d",
                   $time, want.rsi, got.rsi);
          fail_count++;
        end
        if (got.valid !== want.valid) begin
          $display("%0t: rsi_valid mismatch: expected %0d, actual %0d",
                   $time, want.valid, got.valid);
          fail_count++;
        end
        if (!want.valid) n_invalid++;
        else if (want.sig == SIG_BUY) n_buy++;
        else if (want.sig == SIG_SELL) n_sell++;
        else n_none++;
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("rsi_threshold_signal_top test failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned           r;
    int unsigned           phase_len;
    int unsigned           up_pct;
    logic [31:0]           step_max;
    logic [31:0]           span;
    logic [PRICE_IN_W-1:0] walk;
    logic [WINDOW_W-1:0]   win;
    logic [LEVEL_W-1:0]    lo;
    logic [LEVEL_W-1:0]    hi;

    rst_ni        <= 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_WINDOW;
    cfg_data_i    = '0;
    win_reg       = WINDOW_RST;
    lo_level      = OVERSOLD_RST;
    hi_level      = OVERBOUGHT_RST;
    last_price    = '0;
    seen          = 0;
    ring_ptr      = 0;
    gains         = '0;
    losses        = '0;
    tx_idle_pct   = 20;
    rx_idle_pct   = 20;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_PLAN[i]) begin
      if (DIRECTED_PLAN[i].kind == ROW_WRITE) write_reg(DIRECTED_PLAN[i].idx, DIRECTED_PLAN[i].data);
      else push_price(DIRECTED_PLAN[i].price, DIRECTED_PLAN[i].chk, DIRECTED_PLAN[i].res);
    end

    while (prices_sent < ITEMS_TOTAL) begin
      case ($urandom_range(0, 2))
        0: tx_idle_pct = 0;
        1: tx_idle_pct = 10;
        default: tx_idle_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: rx_idle_pct = 0;
        1: rx_idle_pct = 10;
        default: rx_idle_pct = 40;
      endcase

      if ($urandom_range(0, 9) < 6) begin
        r = $urandom_range(0, 99);
        if (r < 60) win = $urandom_range(1, 16);
        else if (r < 80) win = $urandom_range(17, 64);
        else if (r < 87) win = 7'd64;
        else if (r < 92) win = 7'd0;
        else if (r < 96) win = 7'd1;
        else win = $urandom_range(65, 127);
        if ($urandom_range(0, 3) == 0) write_reg(REG_WINDOW, {8'($urandom), win});
        else write_reg(REG_WINDOW, {8'd0, win});
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        lo = $urandom_range(0, 12800);
        hi = $urandom_range(12800, 25600);
      end else if (r < 85) begin
        lo = $urandom_range(0, 1) ? 15'd0 : 15'd25600;
        hi = $urandom_range(0, 1) ? 15'd0 : 15'd25600;
      end else begin
        lo = $urandom_range(0, 32767);
        hi = $urandom_range(0, 32767);
      end
      if ($urandom_range(0, 1)) write_reg(REG_OVERSOLD, lo);
      if ($urandom_range(0, 1)) write_reg(REG_OVERBOUGHT, hi);
      if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, 15'($urandom));

      phase_len = $urandom_range(20, 110);
      walk      = $urandom;
      up_pct    = $urandom_range(5, 95);
      step_max  = 32'hFFFF_FFFF >> $urandom_range(1, 31);
      repeat (phase_len) begin
        calm = (prices_sent >= ITEMS_TOTAL - CALM_ITEMS);
        r = $urandom_range(0, 99);
        if (r < 70) begin
          span = $urandom_range(0, step_max);
          if ($urandom_range(0, 99) < up_pct) walk = walk + span;
          else walk = walk - span;
        end else if (r < 80) begin
          walk = walk;  // unchanged price
        end else if (r < 90) begin
          walk = $urandom;
        end else if (r < 95) begin
          walk = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end else begin
          walk = walk ^ (32'd1 << $urandom_range(0, 31));
        end
        push_price(walk, 1'b0, '0);
      end
      phase_count++;
    end

    s_axis_tvalid <= 1'b0;
    while (pending_rsi.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d prices in %0d random phases plus the directed plan",
             prices_sent, phase_count);
    $display("results: %0d buy, %0d sell, %0d none, %0d before the window filled",
             n_buy, n_sell, n_none, n_invalid);
    if (fail_count == 0) begin
      $display("rsi_threshold_signal_top test passed");
    end else begin
      $display("rsi_threshold_signal_top test failed");
    end
    $finish;
  end

endmodule
